### sv/ndtw_pkg.sv
`default_nettype none

package ndtw_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned COST_W   = 32;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned DVD_W    = COST_W + FRAC_W;
  localparam int unsigned NORM_W   = 24;
  localparam int unsigned QLEN_W   = 11;

  typedef struct packed {
    logic                kind;
    logic [IDX_W-1:0]    template_index;
    logic signed [SAMPLE_W-1:0] sample;
    logic                last;
  } ndtw_in_t;

  typedef struct packed {
    logic [NORM_W-1:0] distance_normalized;
    logic [COST_W-1:0] path_cost;
    logic [QLEN_W-1:0] query_length;
    logic              saturated;
  } ndtw_out_t;

  // wavefront token handed from one cell to the next
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              ovf;
    logic [COST_W-1:0] up;
    logic [COST_W-1:0] diag;
  } ndtw_wave_t;

endpackage

`default_nettype wire

### sv/ndtw_cell.sv
`default_nettype none

module ndtw_cell #(
  parameter int unsigned CELL_INDEX  = 0,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned M_W         = 9
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [M_W-1:0]                m_i,
  input  wire logic                          tpl_we_i,
  input  wire logic [ndtw_pkg::IDX_W-1:0]    tpl_idx_i,
  input  wire logic [SAMPLE_BITS-1:0]        tpl_data_i,
  input  wire ndtw_pkg::ndtw_wave_t          wave_i,
  input  wire logic [SAMPLE_BITS-1:0]        x_i,
  output ndtw_pkg::ndtw_wave_t               wave_o,
  output logic [SAMPLE_BITS-1:0]             x_o
);
  import ndtw_pkg::*;

  logic [SAMPLE_BITS-1:0] tpl_q;
  logic [COST_W-1:0]      cost_q;
  ndtw_wave_t             wave_q;
  logic [SAMPLE_BITS-1:0] x_q;

  logic                   active;
  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]   absd;
  logic [COST_W-1:0]      best;
  logic [COST_W:0]        sum;
  logic                   sat;
  logic [COST_W-1:0]      new_cost;
  ndtw_wave_t             wave_d;

  always_comb begin
    active = M_W'(CELL_INDEX) < m_i;
    diff = $signed({tpl_q[SAMPLE_BITS-1], tpl_q}) - $signed({x_i[SAMPLE_BITS-1], x_i});
    absd = diff[SAMPLE_BITS] ? $unsigned(-diff) : $unsigned(diff);
    if (wave_i.first) begin
      best = wave_i.up;
    end else begin
      best = (wave_i.diag < cost_q) ? wave_i.diag : cost_q;
      best = (wave_i.up < best) ? wave_i.up : best;
    end
    sum      = {1'b0, best} + (COST_W+1)'(absd);
    sat      = sum[COST_W];
    new_cost = sat ? '1 : sum[COST_W-1:0];
    wave_d   = wave_i;
    // rows beyond the length in use pass the token through untouched
    if (active) begin
      wave_d.up   = new_cost;
      wave_d.diag = cost_q;
      wave_d.ovf  = wave_i.ovf | sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tpl_we_i && (32'(tpl_idx_i) == CELL_INDEX)) begin
      tpl_q <= tpl_data_i;
    end
    if (wave_i.valid && active) begin
      cost_q <= new_cost;
    end
    if (wave_i.valid) begin
      x_q <= x_i;
    end
  end

  assign wave_o = wave_q;
  assign x_o    = x_q;

endmodule

`default_nettype wire

### sv/ndtw_divider.sv
`default_nettype none

module ndtw_divider #(
  parameter int unsigned DIV_W = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ndtw_pkg::DVD_W-1:0]    dividend_i,
  input  wire logic [DIV_W-1:0]              divisor_i,
  output logic                               done_o,
  output logic [ndtw_pkg::DVD_W-1:0]         quotient_o
);
  import ndtw_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W:0]   rem_q;
  logic [DIV_W-1:0] div_q;
  logic [DVD_W-1:0] quo_q;

  logic [DIV_W:0]   rem_sh;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[DIV_W-1:0], quo_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### sv/normalized_dtw_distance_unit.sv
// Template write: accepted while idle, and the block stays ready for the next item.
// Query sample: the wavefront walks the cell chain, one cell per cycle, and the block
// takes no new sample until the token has left the last cell, whatever the length in use.
// Last query sample: the serial divider runs, then the result waits until the output is free.
// Reset (async, active low) clears control, length (to 1), query count and flags;
// template and cost registers in the cells come up undefined and need no clearing.
`default_nettype none

module normalized_dtw_distance_unit #(
  parameter int unsigned MAX_TEMPLATE = 256,
  parameter int unsigned MAX_QUERY    = 1024,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ndtw_pkg::ndtw_in_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ndtw_pkg::ndtw_out_t              out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ndtw_pkg::LEN_W-1:0]  cfg_data_i
);
  import ndtw_pkg::*;

  localparam int unsigned TCLOG = $clog2(MAX_TEMPLATE + 1);
  localparam int unsigned MW    = (TCLOG > LEN_W) ? TCLOG : LEN_W;
  localparam int unsigned QW    = $clog2(MAX_QUERY + 1);
  localparam int unsigned DW    = ((MW > QW) ? MW : QW) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]        state_q;
  logic [LEN_W-1:0]  len_q;
  logic [QW-1:0]     cnt_q;
  logic [QW-1:0]     cnt_inc;
  logic              ovf_q;
  logic              last_q;
  logic [QW-1:0]     n_q;
  logic [COST_W-1:0] cost_q;
  logic              sat_q;
  ndtw_out_t         out_q;
  logic              out_valid_q;

  logic [MW-1:0]     m;
  logic              in_acc;
  logic              tpl_we;
  logic              div_start;
  logic              div_done;
  logic [DVD_W-1:0]  quotient;
  logic              out_free;
  logic              norm_sat;

  ndtw_wave_t             wave_w [MAX_TEMPLATE+1];
  logic [SAMPLE_BITS-1:0] x_w    [MAX_TEMPLATE+1];
  logic [SAMPLE_BITS-1:0] raw;

  always_comb begin
    if (len_q == '0) begin
      m = MW'(1);
    end else if (MW'(len_q) > MW'(MAX_TEMPLATE)) begin
      m = MW'(MAX_TEMPLATE);
    end else begin
      m = MW'(len_q);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign tpl_we      = in_acc && !in_data_i.kind;
  assign raw         = SAMPLE_BITS'($unsigned(in_data_i.sample));
  assign cnt_inc     = (cnt_q < QW'(MAX_QUERY)) ? (cnt_q + QW'(1)) : cnt_q;

  // head token: first column adds zero at row 0, later columns see only the left value
  always_comb begin
    wave_w[0].valid = in_acc && in_data_i.kind;
    wave_w[0].first = (cnt_q == '0);
    wave_w[0].ovf   = 1'b0;
    wave_w[0].up    = (cnt_q == '0) ? '0 : '1;
    wave_w[0].diag  = (cnt_q == '0) ? '0 : '1;
  end
  assign x_w[0] = raw;

  for (genvar g = 0; g < MAX_TEMPLATE; g++) begin : g_cell
    ndtw_cell #(
      .CELL_INDEX (g),
      .SAMPLE_BITS(SAMPLE_BITS),
      .M_W        (MW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .m_i       (m),
      .tpl_we_i  (tpl_we),
      .tpl_idx_i (in_data_i.template_index),
      .tpl_data_i(raw),
      .wave_i    (wave_w[g]),
      .x_i       (x_w[g]),
      .wave_o    (wave_w[g+1]),
      .x_o       (x_w[g+1])
    );
  end

  assign div_start = (state_q == ST_WALK) && wave_w[MAX_TEMPLATE].valid && last_q;

  ndtw_divider #(
    .DIV_W(DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({wave_w[MAX_TEMPLATE].up, FRAC_W'(0)}),
    .divisor_i (DW'(m) + DW'(n_q)),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign norm_sat = (quotient[DVD_W-1:NORM_W] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_W'(1);
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && (state_q != ST_HOLD)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && in_data_i.kind) begin
            last_q <= in_data_i.last;
            if (cnt_q == QW'(MAX_QUERY)) begin
              ovf_q <= 1'b1;
            end
            cnt_q   <= in_data_i.last ? '0 : cnt_inc;
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (wave_w[MAX_TEMPLATE].valid) begin
            if (last_q) begin
              ovf_q   <= 1'b0;
              state_q <= ST_DIV;
            end else begin
              ovf_q   <= ovf_q | wave_w[MAX_TEMPLATE].ovf;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.kind && in_data_i.last) begin
      n_q <= cnt_inc;
    end
    if (div_start) begin
      cost_q <= wave_w[MAX_TEMPLATE].up;
      sat_q  <= ovf_q | wave_w[MAX_TEMPLATE].ovf;
    end
    if ((state_q == ST_HOLD) && out_free) begin
      out_q.distance_normalized <= norm_sat ? '1 : quotient[NORM_W-1:0];
      out_q.path_cost           <= cost_q;
      out_q.query_length        <= QLEN_W'(n_q);
      out_q.saturated           <= sat_q | norm_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ready_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !wave_w[MAX_TEMPLATE].valid)
    else $error("token left the chain while idle");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_start_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == ST_DIV))
    else $error("divide phase not entered after last query");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QW'(MAX_QUERY))
    else $error("query count beyond its bound");

  a_hold_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_HOLD) && out_free) |=> out_valid_q)
    else $error("result not presented after division");

endmodule

`default_nettype wire
